// File: design/assert_macros.svh
// assertion macros used by the rtl top; empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// combinational check on every rising clock edge out of reset
`define SMC_ASSERT(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond)) \
		else $error("assertion failed");

// implication check, consequent checked on the same clock edge as the antecedent
`define SMC_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define SMC_ASSERT(lbl, clk_s, rst_n_s, cond)
`define SMC_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// File: design/smc_pkg.sv
`default_nettype none

package smc_pkg;

	// operating modes
	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_SPRAY = 2'd1,
		MODE_CLEAN = 2'd2
	} mode_t;

	// key classification result
	typedef enum logic [1:0] {
		KEY_NONE  = 2'd0,
		KEY_SHORT = 2'd1,
		KEY_LONG  = 2'd2
	} key_event_t;

	// configuration port
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_TICKS_PER_HALF = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AUTO_OFF       = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SLEEP_GRACE    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SHORT_PRESS    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CLEAN_OFF      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_CLEAN_CYCLE    = 3'd6;

	// register reset values
	localparam logic [5:0]  RST_TICKS_PER_HALF = 6'd50;
	localparam logic [15:0] RST_AUTO_OFF       = 16'd28800;
	localparam logic [3:0]  RST_SLEEP_GRACE    = 4'd10;
	localparam logic [7:0]  RST_SHORT_PRESS    = 8'd8;
	localparam logic [7:0]  RST_LONG_PRESS     = 8'd200;
	localparam logic [5:0]  RST_CLEAN_OFF      = 6'd20;
	localparam logic [5:0]  RST_CLEAN_CYCLE    = 6'd30;

	// stream widths
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 16;

	typedef struct packed {
		logic [5:0]  ticks_per_half;
		logic [15:0] auto_off;
		logic [3:0]  sleep_grace;
		logic [7:0]  short_press;
		logic [7:0]  long_press;
		logic [5:0]  clean_off;
		logic [5:0]  clean_cycle;
	} cfg_t;

	typedef struct packed {
		logic [5:0]  tick_cnt;
		logic [15:0] half_cnt;
		logic [3:0]  grace_cnt;
		logic [7:0]  press_cnt;
		logic        long_reported;
		mode_t       mode;
		logic        spray_on;
		logic        led;
		logic        blink;
		logic [5:0]  clean_cnt;
		logic        low_voltage;
	} state_t;

	typedef struct packed {
		logic       sleep_entered;
		logic       low_voltage;
		key_event_t key_event;
		logic       blink_line;
		logic       led_latch;
		logic       spray_enable;
		mode_t      mode;
	} result_t;

endpackage

`default_nettype wire

// File: design/smc_cfg_regs.sv
`default_nettype none

module smc_cfg_regs
	import smc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	// register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_half <= RST_TICKS_PER_HALF;
			cfg_q.auto_off       <= RST_AUTO_OFF;
			cfg_q.sleep_grace    <= RST_SLEEP_GRACE;
			cfg_q.short_press    <= RST_SHORT_PRESS;
			cfg_q.long_press     <= RST_LONG_PRESS;
			cfg_q.clean_off      <= RST_CLEAN_OFF;
			cfg_q.clean_cycle    <= RST_CLEAN_CYCLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICKS_PER_HALF: cfg_q.ticks_per_half <= cfg_wdata[5:0];
				REG_AUTO_OFF:       cfg_q.auto_off       <= cfg_wdata[15:0];
				REG_SLEEP_GRACE:    cfg_q.sleep_grace    <= cfg_wdata[3:0];
				REG_SHORT_PRESS:    cfg_q.short_press    <= cfg_wdata[7:0];
				REG_LONG_PRESS:     cfg_q.long_press     <= cfg_wdata[7:0];
				REG_CLEAN_OFF:      cfg_q.clean_off      <= cfg_wdata[5:0];
				REG_CLEAN_CYCLE:    cfg_q.clean_cycle    <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: design/smc_tick_logic.sv
`default_nettype none

module smc_tick_logic
	import smc_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire logic   key_pressed,
	input  wire logic   supply_ok,
	output state_t      nxt,
	output result_t     res
);

	// one tick of the controller, in the order voltage, timers, clean cycle, key, mode
	always_comb begin
		state_t     s;
		logic       slept;
		key_event_t ev;
		logic [7:0] cnt;

		s     = cur;
		slept = 1'b0;
		ev    = KEY_NONE;
		cnt   = '0;

		// voltage check
		if (supply_ok) begin
			s.low_voltage = 1'b0;
		end else begin
			s.low_voltage = 1'b1;
			s.mode        = MODE_OFF;
			s.led         = 1'b1;
			s.grace_cnt   = s.grace_cnt + 4'd1;
			if (s.grace_cnt >= cfg.sleep_grace) begin
				s.half_cnt  = '0;
				s.spray_on  = 1'b0;
				s.blink     = 1'b0;
				s.grace_cnt = '0;
				s.mode      = MODE_OFF;
				slept       = 1'b1;
			end
		end

		// half-second prescaler and auto-off
		s.tick_cnt = s.tick_cnt + 6'd1;
		if (s.tick_cnt == cfg.ticks_per_half) begin
			s.tick_cnt = '0;
			if (s.half_cnt != 16'hFFFF) begin
				s.half_cnt = s.half_cnt + 16'd1;
			end
			if ((s.half_cnt >= cfg.auto_off) || ((s.mode == MODE_OFF) && s.led)) begin
				s.led       = 1'b1;
				s.grace_cnt = s.grace_cnt + 4'd1;
				if (s.grace_cnt >= cfg.sleep_grace) begin
					s.half_cnt  = '0;
					s.spray_on  = 1'b0;
					s.blink     = 1'b0;
					s.grace_cnt = '0;
					s.mode      = MODE_OFF;
					slept       = 1'b1;
				end
			end
		end

		// clean cycle
		if (s.mode == MODE_CLEAN) begin
			if (s.tick_cnt == 6'd0) begin
				s.blink = ~s.blink;
				if (s.clean_cnt == cfg.clean_off) begin
					s.spray_on = 1'b0;
					s.blink    = 1'b0;
				end
				if (s.clean_cnt >= cfg.clean_cycle) begin
					s.clean_cnt = '0;
					s.spray_on  = 1'b1;
				end
				s.clean_cnt = s.clean_cnt + 6'd1;
			end
		end else if (s.mode == MODE_OFF) begin
			s.spray_on = 1'b0;
			s.blink    = 1'b0;
		end

		// key classification
		if (key_pressed) begin
			cnt = (s.press_cnt == 8'hFF) ? 8'hFF : s.press_cnt + 8'd1;
			if (cnt >= cfg.long_press) begin
				cnt = cfg.long_press;
				if (!s.long_reported) begin
					s.long_reported = 1'b1;
					ev              = KEY_LONG;
				end
			end
			s.press_cnt = cnt;
		end else begin
			if (s.press_cnt >= cfg.long_press) begin
				s.long_reported = 1'b0;
			end else if (s.press_cnt >= cfg.short_press) begin
				ev = KEY_SHORT;
			end
			s.press_cnt = '0;
		end

		// mode step and led toggle
		case (ev)
			KEY_SHORT: begin
				s.half_cnt = '0;
				case (s.mode)
					MODE_OFF:   s.mode = MODE_SPRAY;
					MODE_SPRAY: s.mode = MODE_CLEAN;
					default:    s.mode = MODE_OFF;
				endcase
				if (s.mode != MODE_OFF) begin
					s.spray_on = 1'b1;
				end
			end
			KEY_LONG: begin
				s.led = ~s.led;
				if (s.mode == MODE_OFF) begin
					s.half_cnt = '0;
				end
			end
			default: ;
		endcase

		nxt = s;

		res.mode          = s.mode;
		res.spray_enable  = s.spray_on;
		res.led_latch     = s.led;
		res.blink_line    = s.blink;
		res.key_event     = ev;
		res.low_voltage   = s.low_voltage;
		res.sleep_entered = slept;
	end

endmodule

`default_nettype wire

// File: design/sprayer_mode_controller_top.sv
// sprayer mode controller: one input transaction per 10 ms tick, one result each
// path: an input transaction passes the input register, then the result register,
// before its result leaves; m_tready low holds both stages, s_tready drops only when full
// throughput: one tick per cycle unless m_tready stalls; a single combinational pass
// reset: arst_n asynchronous, active low; clears all controller state and handshake
// state, led latch comes up set and the configuration registers take their defaults
`default_nettype none

`include "assert_macros.svh"

module sprayer_mode_controller_top
	import smc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// tdata: [0] key_pressed, [1] supply_ok, [7:2] zero
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,
	// tdata: [1:0] mode, [2] spray_enable, [3] led_latch, [4] blink_line,
	// [6:5] key_event, [7] low_voltage, [8] sleep_entered, [15:9] zero
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t result_q;
	logic    valid_s1;
	logic    key_s1;
	logic    ok_s1;
	logic    valid_q;
	logic    out_free;
	logic    advance;

	smc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	smc_tick_logic u_tick (
		.cfg         (cfg),
		.cur         (state_q),
		.key_pressed (key_s1),
		.supply_ok   (ok_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	// handshake: the result register frees when empty or taken
	assign out_free = !valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata[0];
			ok_s1  <= s_tdata[1];
		end
	end

	// controller state, updated once per tick as it moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				tick_cnt:      '0,
				half_cnt:      '0,
				grace_cnt:     '0,
				press_cnt:     '0,
				long_reported: 1'b0,
				mode:          MODE_OFF,
				spray_on:      1'b0,
				led:           1'b1,
				blink:         1'b0,
				clean_cnt:     '0,
				low_voltage:   1'b0
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, result_q};

	// checks on the controller and its pipeline
	`SMC_ASSERT(a_mode_legal, clk, arst_n, !m_tvalid || (m_tdata[1:0] != 2'd3))
	`SMC_ASSERT_IMPL(a_sleep_off, clk, arst_n, m_tvalid && m_tdata[8] && (m_tdata[6:5] == KEY_NONE), (m_tdata[1:0] == MODE_OFF) && !m_tdata[2])
	`SMC_ASSERT_IMPL(a_low_v_off, clk, arst_n, m_tvalid && m_tdata[7] && (m_tdata[6:5] == KEY_NONE), m_tdata[1:0] == MODE_OFF)
	`SMC_ASSERT_IMPL(a_stall_why, clk, arst_n, !s_tready, valid_s1 && valid_q && !m_tready)

endmodule

`default_nettype wire

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smc_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef enum logic [2:0] {
		P_DEFAULT, P_TWO_SLEEP, P_ZERO, P_FAST, P_HIGH, P_ONES, P_CLEAN
	} preset_t;

	typedef struct packed {
		row_kind_t kind;
		logic      key;
		logic      ok;
		logic [7:0] reps;
		logic      typed;
		result_t   res;
		preset_t   preset;
	} stim_row_t;

	// fields: ticks_per_half, auto_off, sleep_grace, short, long, clean_off, clean_cycle
	localparam cfg_t PRESETS [7] = '{
		'{RST_TICKS_PER_HALF, RST_AUTO_OFF, RST_SLEEP_GRACE, RST_SHORT_PRESS,
		  RST_LONG_PRESS, RST_CLEAN_OFF, RST_CLEAN_CYCLE},
		'{6'd22, 16'd28800, 4'd1, 8'd8, 8'd1, 6'd20, 6'd30},
		'{6'd0, 16'd0, 4'd0, 8'd0, 8'd0, 6'd0, 6'd0},
		'{6'd2, 16'd40, 4'd3, 8'd2, 8'd12, 6'd5, 6'd8},
		'{6'd63, 16'd65535, 4'd15, 8'd255, 8'd255, 6'd63, 6'd63},
		'{6'd1, 16'd1, 4'd1, 8'd1, 8'd2, 6'd0, 6'd0},
		'{6'd1, 16'd65535, 4'd15, 8'd1, 8'd6, 6'd3, 6'd5}
	};

	localparam result_t RES_AFTER_RESET = '{sleep_entered: 1'b0, low_voltage: 1'b0,
		key_event: KEY_NONE, blink_line: 1'b0, led_latch: 1'b1, spray_enable: 1'b0,
		mode: MODE_OFF};
	localparam result_t RES_LOW_SUPPLY = '{sleep_entered: 1'b0, low_voltage: 1'b1,
		key_event: KEY_NONE, blink_line: 1'b0, led_latch: 1'b1, spray_enable: 1'b0,
		mode: MODE_OFF};
	localparam result_t RES_DOUBLE_SLEEP = '{sleep_entered: 1'b1, low_voltage: 1'b1,
		key_event: KEY_NONE, blink_line: 1'b0, led_latch: 1'b1, spray_enable: 1'b0,
		mode: MODE_OFF};

	// directed part: reset state, low supply, two short presses up to clean mode,
	// double sleep in one tick, long press at ceiling one, all registers zero
	localparam stim_row_t DIRECTED [11] = '{
		'{ROW_TICK, 1'b0, 1'b1, 8'd1, 1'b1, RES_AFTER_RESET, P_DEFAULT},
		'{ROW_TICK, 1'b0, 1'b0, 8'd1, 1'b1, RES_LOW_SUPPLY, P_DEFAULT},
		'{ROW_TICK, 1'b1, 1'b1, 8'd8, 1'b0, '0, P_DEFAULT},
		'{ROW_TICK, 1'b0, 1'b1, 8'd1, 1'b0, '0, P_DEFAULT},
		'{ROW_TICK, 1'b1, 1'b1, 8'd9, 1'b0, '0, P_DEFAULT},
		'{ROW_TICK, 1'b0, 1'b1, 8'd1, 1'b0, '0, P_DEFAULT},
		'{ROW_CFG, 1'b0, 1'b0, 8'd0, 1'b0, '0, P_TWO_SLEEP},
		'{ROW_TICK, 1'b0, 1'b0, 8'd1, 1'b1, RES_DOUBLE_SLEEP, P_DEFAULT},
		'{ROW_TICK, 1'b1, 1'b1, 8'd2, 1'b0, '0, P_DEFAULT},
		'{ROW_CFG, 1'b0, 1'b0, 8'd0, 1'b0, '0, P_ZERO},
		'{ROW_TICK, 1'b1, 1'b0, 8'd3, 1'b0, '0, P_DEFAULT}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	// controller image kept in step with the block
	state_t  ctl;
	cfg_t    live_cfg;
	bit      sleep_seen;
	result_t pending_results [$];
	int      error_count = 0;
	bit      idle_on = 1'b1;
	int      quiet_cycles = 0;

	sprayer_mode_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// spray stop also clears the blink line
	function automatic void halt_spray();
		ctl.spray_on = 1'b0;
		ctl.blink = 1'b0;
	endfunction

	// one sleep condition; enough of them puts the controller to sleep
	function automatic void count_grace();
		ctl.grace_cnt = ctl.grace_cnt + 4'd1;
		if (ctl.grace_cnt >= live_cfg.sleep_grace) begin
			ctl.half_cnt = '0;
			halt_spray();
			ctl.grace_cnt = '0;
			ctl.mode = MODE_OFF;
			sleep_seen = 1'b1;
		end
	endfunction

	// advance the controller image by one tick and return what the block reports
	function automatic result_t tick_outcome(logic key, logic ok);
		key_event_t ev;
		logic [7:0] cnt;
		result_t r;
		ev = KEY_NONE;
		sleep_seen = 1'b0;
		// supply check
		if (ok) begin
			ctl.low_voltage = 1'b0;
		end else begin
			ctl.low_voltage = 1'b1;
			ctl.mode = MODE_OFF;
			ctl.led = 1'b1;
			count_grace();
		end
		// prescaler and auto-off
		ctl.tick_cnt = ctl.tick_cnt + 6'd1;
		if (ctl.tick_cnt == live_cfg.ticks_per_half) begin
			ctl.tick_cnt = '0;
			if (ctl.half_cnt != 16'hFFFF)
				ctl.half_cnt = ctl.half_cnt + 16'd1;
			if (ctl.half_cnt >= live_cfg.auto_off || (ctl.mode == MODE_OFF && ctl.led)) begin
				ctl.led = 1'b1;
				count_grace();
			end
		end
		// clean cycle
		if (ctl.mode == MODE_CLEAN) begin
			if (ctl.tick_cnt == 6'd0) begin
				ctl.blink = ~ctl.blink;
				if (ctl.clean_cnt == live_cfg.clean_off)
					halt_spray();
				if (ctl.clean_cnt >= live_cfg.clean_cycle) begin
					ctl.clean_cnt = '0;
					ctl.spray_on = 1'b1;
				end
				ctl.clean_cnt = ctl.clean_cnt + 6'd1;
			end
		end else if (ctl.mode == MODE_OFF) begin
			halt_spray();
		end
		// key classification
		if (key) begin
			cnt = (ctl.press_cnt == 8'hFF) ? 8'hFF : ctl.press_cnt + 8'd1;
			if (cnt >= live_cfg.long_press) begin
				cnt = live_cfg.long_press;
				if (!ctl.long_reported) begin
					ctl.long_reported = 1'b1;
					ev = KEY_LONG;
				end
			end
			ctl.press_cnt = cnt;
		end else begin
			if (ctl.press_cnt >= live_cfg.long_press)
				ctl.long_reported = 1'b0;
			else if (ctl.press_cnt >= live_cfg.short_press)
				ev = KEY_SHORT;
			ctl.press_cnt = '0;
		end
		// mode step and led toggle
		if (ev == KEY_SHORT) begin
			ctl.half_cnt = '0;
			ctl.mode = (ctl.mode >= MODE_CLEAN) ? MODE_OFF : mode_t'(ctl.mode + 2'd1);
			if (ctl.mode != MODE_OFF)
				ctl.spray_on = 1'b1;
		end else if (ev == KEY_LONG) begin
			ctl.led = ~ctl.led;
			if (ctl.mode == MODE_OFF)
				ctl.half_cnt = '0;
		end
		r.mode = ctl.mode;
		r.spray_enable = ctl.spray_on;
		r.led_latch = ctl.led;
		r.blink_line = ctl.blink;
		r.key_event = ev;
		r.low_voltage = ctl.low_voltage;
		r.sleep_entered = sleep_seen;
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// one tick transaction; called and returns at a falling edge
	task automatic send_tick(logic key, logic ok, logic typed, result_t typed_res);
		int gap;
		result_t predicted;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, ok, key};
		do @(posedge clk); while (!s_tready);
		predicted = tick_outcome(key, ok);
		pending_results.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// hold off input until every result is back, then rewrite all registers
	task automatic apply_config(cfg_t c);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_TICKS_PER_HALF, CfgDataW'(c.ticks_per_half));
		write_reg(REG_AUTO_OFF, CfgDataW'(c.auto_off));
		write_reg(REG_SLEEP_GRACE, CfgDataW'(c.sleep_grace));
		write_reg(REG_SHORT_PRESS, CfgDataW'(c.short_press));
		write_reg(REG_LONG_PRESS, CfgDataW'(c.long_press));
		write_reg(REG_CLEAN_OFF, CfgDataW'(c.clean_off));
		write_reg(REG_CLEAN_CYCLE, CfgDataW'(c.clean_cycle));
		cfg_we <= 1'b0;
		live_cfg = c;
	endtask

	// mostly key presses sized around the thresholds, some random noise
	task automatic run_phase(int items);
		int sent;
		int hold;
		int rest;
		sent = 0;
		while (sent < items) begin
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_tick(1'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
				end
			end else begin
				case ($urandom_range(0, 2))
					0: hold = (live_cfg.short_press > 1) ?
						$urandom_range(1, live_cfg.short_press - 1) : 1;
					1: hold = $urandom_range(live_cfg.short_press, live_cfg.short_press + 3);
					default: hold = $urandom_range(live_cfg.long_press, live_cfg.long_press + 4);
				endcase
				if (hold < 1)
					hold = 1;
				if (hold > 40)
					hold = $urandom_range(1, 12);
				rest = $urandom_range(1, 5);
				repeat (hold) begin
					send_tick(1'b1, $urandom_range(0, 39) != 0, 1'b0, '0);
					sent++;
				end
				repeat (rest) begin
					send_tick(1'b0, $urandom_range(0, 39) != 0, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	// stimulus
	initial begin : stimulus
		cfg_t rnd_cfg;
		ctl = '0;
		ctl.led = 1'b1;
		live_cfg = PRESETS[P_DEFAULT];
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG)
				apply_config(PRESETS[DIRECTED[i].preset]);
			else
				repeat (DIRECTED[i].reps)
					send_tick(DIRECTED[i].key, DIRECTED[i].ok, DIRECTED[i].typed,
						DIRECTED[i].res);
		end

		apply_config(PRESETS[P_FAST]);
		run_phase(90);
		apply_config(PRESETS[P_CLEAN]);
		run_phase(70);
		apply_config(PRESETS[P_HIGH]);
		run_phase(40);
		apply_config(PRESETS[P_ONES]);
		run_phase(30);
		apply_config(PRESETS[P_ZERO]);
		run_phase(20);
		repeat (3) begin
			rnd_cfg.ticks_per_half = 6'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 63) : $urandom_range(1, 4));
			rnd_cfg.auto_off = 16'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(1, 60));
			rnd_cfg.sleep_grace = 4'($urandom_range(0, 15));
			rnd_cfg.short_press = 8'($urandom_range(0, 6));
			rnd_cfg.long_press = 8'($urandom_range(0, 20));
			rnd_cfg.clean_off = 6'($urandom_range(0, 12));
			rnd_cfg.clean_cycle = 6'($urandom_range(0, 12));
			apply_config(rnd_cfg);
			run_phase(35);
		end
		apply_config(PRESETS[P_DEFAULT]);
		run_phase(40);

		// drain and let the pipeline settle
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// result side: random back-pressure and field checks
	initial begin : result_sink
		int gap;
		result_t got;
		result_t want;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = result_t'(m_tdata[8:0]);
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected, tdata %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("mode", want.mode, got.mode);
				compare_field("spray_enable", want.spray_enable, got.spray_enable);
				compare_field("led_latch", want.led_latch, got.led_latch);
				compare_field("blink_line", want.blink_line, got.blink_line);
				compare_field("key_event", want.key_event, got.key_event);
				compare_field("low_voltage", want.low_voltage, got.low_voltage);
				compare_field("sleep_entered", want.sleep_entered, got.sleep_entered);
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

endmodule
